[hw/rtl/mep_pkg.sv]
// Shared constants, types and helper functions of the escape-time pixel block.
package mep_pkg;

   // number formats
   localparam int FRAC_BITS = 40;
   localparam int Z_W       = 48;
   localparam int COL_W     = 11;
   localparam int ROW_W     = 11;
   localparam int STEP_W    = 47;
   localparam int ITER_W    = 16;
   localparam int COLOR_W   = 8;

   // shared multiplier: Z_W-bit magnitudes split into two halves
   localparam int HALF_W  = Z_W / 2;
   localparam int PROD_W  = 2 * HALF_W;
   localparam int ACC_W   = 2 * Z_W;
   // a square is at most 2^(ACC_W-2); truncated by FRAC_BITS
   localparam int SQ_W    = ACC_W - 1 - FRAC_BITS;
   localparam int RI_W    = SQ_W + 1;
   localparam int CPROD_W = COL_W + STEP_W;
   localparam int CSUM_W  = CPROD_W + 2;

   localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
   localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
   localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W+1)'(4) << FRAC_BITS;

   // sequencer phase counter
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(5);
   localparam logic [PHASE_W-1:0] C_PARTS    = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] Z_PARTS    = PHASE_W'(4);

   // accumulate shift codes
   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_HALF = 2'd1;
   localparam logic [1:0] SH_FULL = 2'd2;

   // register file
   localparam int DATA_W     = 64;
   localparam int ADDR_W     = 6;
   localparam int BYTE_OFF_W = 3;
   localparam int REG_IDX_W  = ADDR_W - BYTE_OFF_W;
   localparam logic [REG_IDX_W-1:0] REG_MIN_REAL  = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_MIN_IMAG  = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_STEP_REAL = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = REG_IDX_W'(4);

   localparam logic signed [Z_W-1:0] MIN_RESET  = -(Z_W'(5) << FRAC_BITS);
   localparam logic [STEP_W-1:0]     STEP_RESET = STEP_W'(47'd13743895347);
   localparam logic [ITER_W-1:0]     ITER_RESET = ITER_W'(2);

   typedef struct packed {
      logic signed [Z_W-1:0] min_real;
      logic signed [Z_W-1:0] min_imag;
      logic [STEP_W-1:0]     step_real;
      logic [STEP_W-1:0]     step_imag;
      logic [ITER_W-1:0]     max_iter;
   } mep_cfg_type;

   typedef struct packed {
      logic       issue;
      logic       clear;
      logic [1:0] shift_sel;
   } mep_mac_ctl_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } mep_rgb_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CREAL,
      ST_CIMAG,
      ST_CHECK,
      ST_SQ_R,
      ST_SQ_I,
      ST_CROSS,
      ST_TEST,
      ST_UPDATE,
      ST_DONE
   } mep_state_type;

   function automatic logic [Z_W-1:0] mag_z(input logic signed [Z_W-1:0] v);
      logic [Z_W-1:0] u;
      u = v;
      if (v[Z_W-1]) begin
         mag_z = ~u + Z_W'(1);
      end else begin
         mag_z = u;
      end
   endfunction

   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [CSUM_W-1:0] v);
      logic pos_ovf;
      logic neg_ovf;
      pos_ovf = !v[CSUM_W-1] && (|v[CSUM_W-2:Z_W-1]);
      neg_ovf = v[CSUM_W-1] && !(&v[CSUM_W-2:Z_W-1]);
      if (pos_ovf) begin
         sat_z = Z_MAX;
      end else if (neg_ovf) begin
         sat_z = Z_MIN;
      end else begin
         sat_z = v[Z_W-1:0];
      end
   endfunction

   function automatic mep_rgb_type palette_rgb(input logic [2:0] idx);
      mep_rgb_type rgb;
      unique case (idx)
         3'd0: begin
            rgb = {8'd249, 8'd83, 8'd255};
         end
         3'd1: begin
            rgb = {8'd44, 8'd255, 8'd243};
         end
         3'd2: begin
            rgb = {8'd167, 8'd255, 8'd66};
         end
         3'd3: begin
            rgb = {8'd255, 8'd198, 8'd39};
         end
         3'd4: begin
            rgb = {8'd255, 8'd109, 8'd75};
         end
         default: begin
            rgb = '0;
         end
      endcase
      palette_rgb = rgb;
   endfunction

endpackage

[hw/rtl/mep_if.sv]
// Valid/ready channel interfaces for pixel requests and results.
interface mep_req_if;
   import mep_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   modport source (output valid, col, row, input ready);
   modport sink (input valid, col, row, output ready);
endinterface

interface mep_rsp_if;
   import mep_pkg::*;
   logic               valid;
   logic               ready;
   logic [ITER_W-1:0]  iter_count;
   logic               inside_res;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   modport source (output valid, iter_count, inside_res, red, green, blue, input ready);
   modport sink (input valid, iter_count, inside_res, red, green, blue, output ready);
endinterface

[hw/rtl/mep_csr.sv]
// APB-style configuration registers for the escape-time pixel block.
module mep_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mep_pkg::ADDR_W-1:0]   paddr,
   input  logic [mep_pkg::DATA_W-1:0]   pwdata,
   output logic [mep_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output mep_pkg::mep_cfg_type         cfg
);
   import mep_pkg::*;

   mep_cfg_type            cfg_ff;
   mep_cfg_type            cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[ADDR_W-1:BYTE_OFF_W];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_REAL: begin
               cfg_in.min_real = pwdata[Z_W-1:0];
            end
            REG_MIN_IMAG: begin
               cfg_in.min_imag = pwdata[Z_W-1:0];
            end
            REG_STEP_REAL: begin
               cfg_in.step_real = pwdata[STEP_W-1:0];
            end
            REG_STEP_IMAG: begin
               cfg_in.step_imag = pwdata[STEP_W-1:0];
            end
            REG_MAX_ITER: begin
               cfg_in.max_iter = pwdata[ITER_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_REAL: begin
            prdata = {{(DATA_W-Z_W){cfg_ff.min_real[Z_W-1]}}, cfg_ff.min_real};
         end
         REG_MIN_IMAG: begin
            prdata = {{(DATA_W-Z_W){cfg_ff.min_imag[Z_W-1]}}, cfg_ff.min_imag};
         end
         REG_STEP_REAL: begin
            prdata = DATA_W'(cfg_ff.step_real);
         end
         REG_STEP_IMAG: begin
            prdata = DATA_W'(cfg_ff.step_imag);
         end
         REG_MAX_ITER: begin
            prdata = DATA_W'(cfg_ff.max_iter);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_real  <= MIN_RESET;
         cfg_ff.min_imag  <= MIN_RESET;
         cfg_ff.step_real <= STEP_RESET;
         cfg_ff.step_imag <= STEP_RESET;
         cfg_ff.max_iter  <= ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/mep_mac.sv]
// Shared half-width multiplier with a shifted accumulator.
module mep_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  mep_pkg::mep_mac_ctl_type       ctl,
   input  logic [mep_pkg::HALF_W-1:0]     op_a,
   input  logic [mep_pkg::HALF_W-1:0]     op_b,
   output logic [mep_pkg::ACC_W-1:0]      acc
);
   import mep_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   mep_mac_ctl_type   stg_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [ACC_W-1:0]  shifted;

   assign prod_in = op_a * op_b;
   assign acc     = acc_ff;

   always_comb begin
      unique case (stg_ff.shift_sel)
         SH_NONE: begin
            shifted = ACC_W'(prod_ff);
         end
         SH_HALF: begin
            shifted = ACC_W'(prod_ff) << HALF_W;
         end
         SH_FULL: begin
            shifted = ACC_W'(prod_ff) << (2 * HALF_W);
         end
         default: begin
            shifted = '0;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (stg_ff.issue) begin
         acc_in = (stg_ff.clear ? '0 : acc_ff) + shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff <= '0;
      end else begin
         stg_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

[hw/rtl/mep_core.sv]
// Sequencer and datapath: point setup, z = z^2 + c loop and result register.
module mep_core (
   input  logic                  clock,
   input  logic                  reset,
   input  mep_pkg::mep_cfg_type  cfg,
   mep_req_if.sink               req_if,
   mep_rsp_if.source             rsp_if
);
   import mep_pkg::*;

   mep_state_type          state_ff;
   mep_state_type          state_in;
   logic [PHASE_W-1:0]     phase_ff;
   logic [PHASE_W-1:0]     phase_in;
   logic                   phase_last;

   logic [COL_W-1:0]       col_ff;
   logic [COL_W-1:0]       col_in;
   logic [ROW_W-1:0]       row_ff;
   logic [ROW_W-1:0]       row_in;
   logic signed [Z_W-1:0]  cr_ff;
   logic signed [Z_W-1:0]  cr_in;
   logic signed [Z_W-1:0]  ci_ff;
   logic signed [Z_W-1:0]  ci_in;
   logic signed [Z_W-1:0]  r_ff;
   logic signed [Z_W-1:0]  r_in;
   logic signed [Z_W-1:0]  i_ff;
   logic signed [Z_W-1:0]  i_in;
   logic [Z_W-1:0]         mag_r_ff;
   logic [Z_W-1:0]         mag_r_in;
   logic [Z_W-1:0]         mag_i_ff;
   logic [Z_W-1:0]         mag_i_in;
   logic [SQ_W-1:0]        rr_ff;
   logic [SQ_W-1:0]        rr_in;
   logic [SQ_W-1:0]        ii_ff;
   logic [SQ_W-1:0]        ii_in;
   logic [RI_W-1:0]        ri_ff;
   logic [RI_W-1:0]        ri_in;
   logic signed [Z_W-1:0]  dr_ff;
   logic signed [Z_W-1:0]  dr_in;
   logic signed [Z_W-1:0]  xr_ff;
   logic signed [Z_W-1:0]  xr_in;
   logic [ITER_W-1:0]      n_ff;
   logic [ITER_W-1:0]      n_in;
   logic [2:0]             m5_ff;
   logic [2:0]             m5_in;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [ITER_W-1:0]      out_iter_ff;
   logic [ITER_W-1:0]      out_iter_in;
   logic                   out_inside_ff;
   logic                   out_inside_in;
   mep_rgb_type            out_rgb_ff;
   mep_rgb_type            out_rgb_in;

   mep_mac_ctl_type        mac_ctl;
   logic [HALF_W-1:0]      op_a;
   logic [HALF_W-1:0]      op_b;
   logic [ACC_W-1:0]       acc;
   logic [Z_W-1:0]         mag_a;
   logic [Z_W-1:0]         mag_b;
   logic [STEP_W-1:0]      c_step;

   logic                   accept;
   logic                   escape;
   logic                   out_load;
   logic                   pix_inside;
   logic                   ri_big;
   logic                   ri_neg;
   logic signed [Z_W-1:0]  c_min;
   logic signed [CSUM_W-1:0] c_sum;
   logic signed [Z_W-1:0]  c_sat;
   logic signed [Z_W-1:0]  nr;
   logic signed [Z_W-1:0]  ni;

   mep_mac u_mep_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign accept            = req_if.valid && (state_ff == ST_IDLE);
   assign phase_last        = (phase_ff == PHASE_LAST);
   assign escape            = ((SQ_W+1)'(rr_ff) + (SQ_W+1)'(ii_ff)) >= ESC_LIMIT;
   assign out_load          = (state_ff == ST_DONE) && (!out_valid_ff || rsp_if.ready);
   assign pix_inside        = (n_ff == cfg.max_iter);

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.iter_count = out_iter_ff;
   assign rsp_if.inside_res = out_inside_ff;
   assign rsp_if.red        = out_rgb_ff.red;
   assign rsp_if.green      = out_rgb_ff.green;
   assign rsp_if.blue       = out_rgb_ff.blue;

   // c = min + index * step, product taken from the accumulator
   assign c_min  = (state_ff == ST_CIMAG) ? cfg.min_imag : cfg.min_real;
   assign c_sum  = CSUM_W'(c_min) + $signed(CSUM_W'(acc[CPROD_W-1:0]));
   assign c_sat  = sat_z(c_sum);

   // cross term 2*r*i, sign applied after truncation of the magnitude
   assign ri_big = |ri_ff[RI_W-1:Z_W-1];
   assign ri_neg = r_ff[Z_W-1] ^ i_ff[Z_W-1];

   assign nr = sat_z(CSUM_W'(dr_ff) + CSUM_W'(cr_ff));
   assign ni = sat_z(CSUM_W'(xr_ff) + CSUM_W'(ci_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_CREAL;
            end
         end
         ST_CREAL: begin
            if (phase_last) begin
               state_in = ST_CIMAG;
            end else begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
         ST_CIMAG: begin
            if (phase_last) begin
               state_in = ST_CHECK;
            end else begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
         ST_CHECK: begin
            if (n_ff >= cfg.max_iter) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ_R;
            end
         end
         ST_SQ_R: begin
            if (phase_last) begin
               state_in = ST_SQ_I;
            end else begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
         ST_SQ_I: begin
            if (phase_last) begin
               state_in = ST_CROSS;
            end else begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
         ST_CROSS: begin
            if (phase_last) begin
               state_in = ST_TEST;
            end else begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
         ST_TEST: begin
            if (escape) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // multiplier issue: one partial product per phase, then drain phases
   always_comb begin
      mac_ctl = '0;
      op_a    = '0;
      op_b    = '0;
      mag_a   = mag_r_ff;
      mag_b   = mag_r_ff;
      c_step  = (state_ff == ST_CIMAG) ? cfg.step_imag : cfg.step_real;
      unique case (state_ff)
         ST_CREAL, ST_CIMAG: begin
            if (phase_ff < C_PARTS) begin
               mac_ctl.issue     = 1'b1;
               mac_ctl.clear     = (phase_ff == '0);
               mac_ctl.shift_sel = phase_ff[0] ? SH_HALF : SH_NONE;
               op_a = (state_ff == ST_CIMAG) ? HALF_W'(row_ff) : HALF_W'(col_ff);
               op_b = phase_ff[0] ? HALF_W'(c_step[STEP_W-1:HALF_W])
                                  : c_step[HALF_W-1:0];
            end
         end
         ST_SQ_R, ST_SQ_I, ST_CROSS: begin
            if (state_ff == ST_SQ_I) begin
               mag_a = mag_i_ff;
               mag_b = mag_i_ff;
            end else if (state_ff == ST_CROSS) begin
               mag_b = mag_i_ff;
            end
            if (phase_ff < Z_PARTS) begin
               mac_ctl.issue = 1'b1;
               mac_ctl.clear = (phase_ff == '0);
               unique case (phase_ff[1:0])
                  2'b00: begin
                     mac_ctl.shift_sel = SH_NONE;
                  end
                  2'b01, 2'b10: begin
                     mac_ctl.shift_sel = SH_HALF;
                  end
                  default: begin
                     mac_ctl.shift_sel = SH_FULL;
                  end
               endcase
               op_a = phase_ff[0] ? mag_a[Z_W-1:HALF_W] : mag_a[HALF_W-1:0];
               op_b = phase_ff[1] ? mag_b[Z_W-1:HALF_W] : mag_b[HALF_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      r_in          = r_ff;
      i_in          = i_ff;
      mag_r_in      = mag_r_ff;
      mag_i_in      = mag_i_ff;
      rr_in         = rr_ff;
      ii_in         = ii_ff;
      ri_in         = ri_ff;
      dr_in         = dr_ff;
      xr_in         = xr_ff;
      n_in          = n_ff;
      m5_in         = m5_ff;
      out_iter_in   = out_iter_ff;
      out_inside_in = out_inside_ff;
      out_rgb_in    = out_rgb_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_in = req_if.col;
               row_in = req_if.row;
               r_in   = '0;
               i_in   = '0;
               n_in   = '0;
               m5_in  = '0;
            end
         end
         ST_CREAL: begin
            if (phase_last) begin
               cr_in = c_sat;
            end
         end
         ST_CIMAG: begin
            if (phase_last) begin
               ci_in = c_sat;
            end
         end
         ST_CHECK: begin
            mag_r_in = mag_z(r_ff);
            mag_i_in = mag_z(i_ff);
         end
         ST_SQ_R: begin
            if (phase_last) begin
               rr_in = acc[FRAC_BITS +: SQ_W];
            end
         end
         ST_SQ_I: begin
            if (phase_last) begin
               ii_in = acc[FRAC_BITS +: SQ_W];
            end
         end
         ST_CROSS: begin
            if (phase_last) begin
               ri_in = acc[FRAC_BITS-1 +: RI_W];
            end
         end
         ST_TEST: begin
            // when the loop goes on both squares are below 4.0, so no saturation
            dr_in = $signed(rr_ff[Z_W-1:0]) - $signed(ii_ff[Z_W-1:0]);
            if (ri_neg) begin
               xr_in = ri_big ? Z_MIN : $signed(Z_W'(0) - ri_ff[Z_W-1:0]);
            end else begin
               xr_in = ri_big ? Z_MAX : $signed(ri_ff[Z_W-1:0]);
            end
         end
         ST_UPDATE: begin
            if ((nr == r_ff) && (ni == i_ff)) begin
               // stuck at a fixed point: count as inside
               n_in = cfg.max_iter;
            end else begin
               r_in  = nr;
               i_in  = ni;
               n_in  = n_ff + ITER_W'(1);
               m5_in = (m5_ff == 3'd4) ? 3'd0 : m5_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               out_iter_in   = n_ff;
               out_inside_in = pix_inside;
               out_rgb_in    = pix_inside ? '0 : palette_rgb(m5_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      r_ff          <= r_in;
      i_ff          <= i_in;
      mag_r_ff      <= mag_r_in;
      mag_i_ff      <= mag_i_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      ri_ff         <= ri_in;
      dr_ff         <= dr_in;
      xr_ff         <= xr_in;
      n_ff          <= n_in;
      m5_ff         <= m5_in;
      out_iter_ff   <= out_iter_in;
      out_inside_ff <= out_inside_in;
      out_rgb_ff    <= out_rgb_in;
   end

endmodule

[hw/rtl/mandelbrot_escape_pixel.sv]
// Top level of the escape-time pixel evaluator.
//
// req_if carries one pixel (col, row); rsp_if returns iter_count, inside_res
// and an RGB color. Both are valid/ready channels: a transfer happens on a
// rising clock edge with valid and ready high. Registers (min_real,
// min_imag, step_real, step_imag, max_iterations) sit at APB-style byte
// addresses 0, 8, 16, 24, 32; unguarded, so write them only while idle.
//
// One pixel at a time. A single 24x24 multiplier with a shifted accumulator
// does all products, four partial products per 48x48 square. Setting up c
// computes the real part, then the imaginary part. Each loop pass runs the
// limit check, the squares r*r and i*i, the cross product r*i, the escape
// test and the update. The loop stops when the limit is reached, when the
// point escapes or when a pass hits a fixed point. req_if.ready is high only
// while the sequencer is idle.
//
// The result sits in an output register: the next pixel is taken while it
// waits. A stalled receiver holds the finished next result in the sequencer.
// Synchronous reset empties the output register, idles the sequencer and
// loads the register defaults.
module mandelbrot_escape_pixel (
   input  logic                        clock,
   input  logic                        reset,
   mep_req_if.sink                     req_if,
   mep_rsp_if.source                   rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mep_pkg::ADDR_W-1:0]  paddr,
   input  logic [mep_pkg::DATA_W-1:0]  pwdata,
   output logic [mep_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import mep_pkg::*;

   mep_cfg_type cfg;

   mep_csr u_mep_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mep_core u_mep_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

[hw/rtl/mep_checker.sv]
// Port-level assertions for the escape-time pixel block, bound to the top level.
module mep_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mep_pkg::ITER_W-1:0]        rsp_iter_count,
   input logic                              rsp_inside_res,
   input logic [mep_pkg::COLOR_W-1:0]       rsp_red,
   input logic [mep_pkg::COLOR_W-1:0]       rsp_green,
   input logic [mep_pkg::COLOR_W-1:0]       rsp_blue
);
   import mep_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_iter_count)
         && $stable(rsp_inside_res) && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("result changed while stalled");

   // one pixel at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_red == '0 && rsp_green == '0
         && rsp_blue == '0)
      else $error("inside pixel not black");

   // every palette entry has all three bytes nonzero
   a_outside_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_red != '0 && rsp_green != '0
         && rsp_blue != '0)
      else $error("escaped pixel has no palette color");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_iter_count (rsp_if.iter_count),
   .rsp_inside_res (rsp_if.inside_res),
   .rsp_red        (rsp_if.red),
   .rsp_green      (rsp_if.green),
   .rsp_blue       (rsp_if.blue)
);

[sim/mep_escape_checker.sv]
`timescale 1ns / 1ps
// Checker for the escape-time pixel block: predicts every pixel and compares results.
module mep_escape_checker (
   input  logic                       clock,
   input  logic                       reset,
   mep_req_if                         req_if,
   mep_rsp_if                         rsp_if,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [mep_pkg::ADDR_W-1:0] paddr,
   input  logic [mep_pkg::DATA_W-1:0] pwdata,
   output int                         mismatch_count,
   output int                         outstanding
);
   import mep_pkg::*;

   typedef struct packed {
      logic [ITER_W-1:0]    iter;
      logic                 in_set;
      logic [3*COLOR_W-1:0] rgb;
   } pixel_color_type;

   localparam longint      Z_TOP     = (64'sd1 <<< (Z_W - 1)) - 1;
   localparam longint      Z_BOTTOM  = -Z_TOP - 1;
   localparam logic [95:0] SQ_CAP    = 96'd1 << 62;
   localparam logic [63:0] ESCAPE_R2 = 64'd4 << FRAC_BITS;

   // local copy of the view registers
   longint      view_min_re;
   longint      view_min_im;
   longint      view_step_re;
   longint      view_step_im;
   int unsigned iter_limit;

   pixel_color_type expected_pixels[$];

   function automatic longint clamp_z(input longint v);
      if (v > Z_TOP) begin
         return Z_TOP;
      end else if (v < Z_BOTTOM) begin
         return Z_BOTTOM;
      end
      return v;
   endfunction

   // |a|*|b| shifted right by sh, truncated and capped at SQ_CAP
   function automatic logic [63:0] prod_mag(input longint a, input longint b, input int sh);
      logic [63:0] ua;
      logic [63:0] ub;
      logic [95:0] p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {32'd0, ua} * {32'd0, ub};
      p = p >> sh;
      if (p > SQ_CAP) begin
         p = SQ_CAP;
      end
      return p[63:0];
   endfunction

   // sign applied after truncation, then clamped to the z range
   function automatic longint prod_fx(input longint a, input longint b, input int sh);
      longint s;
      s = longint'(prod_mag(a, b, sh));
      if ((a < 0) != (b < 0)) begin
         s = -s;
      end
      return clamp_z(s);
   endfunction

   function automatic logic [3*COLOR_W-1:0] hue(input int unsigned k);
      unique case (k)
         0: begin
            return 24'hF953FF;
         end
         1: begin
            return 24'h2CFFF3;
         end
         2: begin
            return 24'hA7FF42;
         end
         3: begin
            return 24'hFFC627;
         end
         default: begin
            return 24'hFF6D4B;
         end
      endcase
   endfunction

   function automatic pixel_color_type escape_pixel(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
      pixel_color_type res;
      longint          cr;
      longint          ci;
      longint          zr;
      longint          zi;
      longint          nr;
      longint          ni;
      logic [63:0]     rr;
      logic [63:0]     ii;
      int unsigned     n;
      cr = clamp_z(view_min_re + longint'(col) * view_step_re);
      ci = clamp_z(view_min_im + longint'(row) * view_step_im);
      zr = 0;
      zi = 0;
      n = 0;
      while (n < iter_limit) begin
         rr = prod_mag(zr, zr, FRAC_BITS);
         ii = prod_mag(zi, zi, FRAC_BITS);
         if (rr + ii >= ESCAPE_R2) begin
            break;
         end
         nr = clamp_z(prod_fx(zr, zr, FRAC_BITS) - prod_fx(zi, zi, FRAC_BITS) + cr);
         ni = clamp_z(prod_fx(zr, zi, FRAC_BITS - 1) + ci);
         // z stuck: counts as inside right away
         if (nr == zr && ni == zi) begin
            n = iter_limit;
            break;
         end
         zr = nr;
         zi = ni;
         n++;
      end
      res.iter = n[ITER_W-1:0];
      res.in_set = (n == iter_limit);
      res.rgb = res.in_set ? '0 : hue(n % 5);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      pixel_color_type want;
      if (reset) begin
         view_min_re = longint'(MIN_RESET);
         view_min_im = longint'(MIN_RESET);
         view_step_re = longint'(STEP_RESET);
         view_step_im = longint'(STEP_RESET);
         iter_limit = ITER_RESET;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            unique case (paddr[ADDR_W-1:BYTE_OFF_W])
               REG_MIN_REAL: begin
                  view_min_re = $signed(pwdata[Z_W-1:0]);
               end
               REG_MIN_IMAG: begin
                  view_min_im = $signed(pwdata[Z_W-1:0]);
               end
               REG_STEP_REAL: begin
                  view_step_re = longint'(pwdata[STEP_W-1:0]);
               end
               REG_STEP_IMAG: begin
                  view_step_im = longint'(pwdata[STEP_W-1:0]);
               end
               REG_MAX_ITER: begin
                  iter_limit = pwdata[ITER_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            expected_pixels.push_back(escape_pixel(req_if.col, req_if.row));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result transfer", 1, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_if.iter_count !== want.iter) begin
                  report_mismatch("iter_count", rsp_if.iter_count, want.iter);
               end
               if (rsp_if.inside_res !== want.in_set) begin
                  report_mismatch("inside_res", rsp_if.inside_res, want.in_set);
               end
               if (rsp_if.red !== want.rgb[23:16]) begin
                  report_mismatch("red", rsp_if.red, want.rgb[23:16]);
               end
               if (rsp_if.green !== want.rgb[15:8]) begin
                  report_mismatch("green", rsp_if.green, want.rgb[15:8]);
               end
               if (rsp_if.blue !== want.rgb[7:0]) begin
                  report_mismatch("blue", rsp_if.blue, want.rgb[7:0]);
               end
            end
         end
      end
      outstanding <= expected_pixels.size();
   end

endmodule

[sim/tb_mandelbrot_escape_pixel.sv]
`timescale 1ns / 1ps
// Testbench top for the escape-time pixel block: stimulus, register setup and verdict.
module tb_mandelbrot_escape_pixel;
   import mep_pkg::*;

   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int END_SLACK    = 64;
   localparam int RANDOM_ITEMS = 555;
   localparam int IDLE_MAX     = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int fail_count;
   int outstanding;
   int cycle_count;
   int req_burst_left;
   int rsp_hold_count;
   int rsp_hold_cycles;

   mep_req_if req_if ();
   mep_rsp_if rsp_if ();

   mandelbrot_escape_pixel u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mep_escape_checker u_escape_chk (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (fail_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
      end
      return $urandom_range(0, IDLE_MAX);
   endfunction

   function automatic logic [COL_W-1:0] draw_index();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 1) ? '1 : '0;
      end
      return COL_W'($urandom_range(0, (1 << COL_W) - 1));
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, {BYTE_OFF_W{1'b0}}};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_view(input longint mr, input longint mi,
                            input logic [STEP_W-1:0] sr, input logic [STEP_W-1:0] si,
                            input logic [ITER_W-1:0] lim);
      csr_write(REG_MIN_REAL, DATA_W'(mr));
      csr_write(REG_MIN_IMAG, DATA_W'(mi));
      csr_write(REG_STEP_REAL, DATA_W'(sr));
      csr_write(REG_STEP_IMAG, DATA_W'(si));
      csr_write(REG_MAX_ITER, DATA_W'(lim));
   endtask

   // valid stays up after the transfer when the next pixel follows at once
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      int gap;
      gap = draw_gap(req_burst_left);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.col <= col;
      req_if.row <= row;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic random_view();
      logic [63:0]       bits_re;
      logic [63:0]       bits_im;
      longint            mr;
      longint            mi;
      logic [STEP_W-1:0] sr;
      logic [STEP_W-1:0] si;
      logic [ITER_W-1:0] lim;
      int                pick;
      bits_re = {$urandom, $urandom};
      bits_im = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         // anywhere in the number range; mostly saturated points
         mr = longint'($signed(bits_re[Z_W-1:0]));
         mi = longint'($signed(bits_im[Z_W-1:0]));
         sr = STEP_W'({$urandom, $urandom});
         si = STEP_W'({$urandom, $urandom});
      end else begin
         // window around the set
         mr = -(64'sd5 <<< 39) + longint'(bits_re[40:0]);
         mi = -(64'sd3 <<< 39) + longint'(bits_im[39:0]);
         sr = STEP_W'($urandom >> $urandom_range(2, 12));
         si = STEP_W'($urandom >> $urandom_range(2, 12));
      end
      pick = $urandom_range(0, 49);
      if (pick == 0) begin
         lim = '0;
      end else if (pick <= 3) begin
         lim = ITER_W'($urandom_range(65, 120));
      end else if (pick <= 13) begin
         lim = ITER_W'($urandom_range(25, 64));
      end else begin
         lim = ITER_W'($urandom_range(1, 24));
      end
      load_view(mr, mi, sr, si, lim);
   endtask

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_mandelbrot_escape_pixel: FAIL");
      $finish;
   end

   initial begin : receiver
      int gap;
      int burst_left;
      int holds_seen;
      rsp_if.ready = 1'b0;
      burst_left = 0;
      holds_seen = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_count != holds_seen) begin
            holds_seen = rsp_hold_count;
            rsp_if.ready <= 1'b0;
            for (int k = 0; k < rsp_hold_cycles; k++) begin
               @(posedge clock);
            end
         end
         gap = draw_gap(burst_left);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin : stimulus
      int random_sent;
      int phase_items;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.col = '0;
      req_if.row = '0;
      rsp_hold_count = 0;
      rsp_hold_cycles = 0;
      req_burst_left = 0;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults, corners of the index range
      send_pixel('0, '0);
      send_pixel('1, '1);
      send_pixel('0, '1);
      send_pixel('1, '0);
      send_pixel(11'd400, 11'd400);
      drain_results();

      // zero limit: always inside and black
      load_view(longint'(MIN_RESET), longint'(MIN_RESET), STEP_RESET, STEP_RESET, '0);
      send_pixel(11'd400, 11'd400);
      send_pixel('1, '0);
      drain_results();

      // c = 0 everywhere: z stuck at zero on the first step, full limit
      load_view(0, 0, '0, '0, '1);
      send_pixel('0, '0);
      send_pixel('1, '1);
      drain_results();

      // far outside with the full limit: escapes after the first update
      load_view(64'sd3 <<< FRAC_BITS, 0, STEP_W'(1), '0, '1);
      send_pixel('0, '0);
      send_pixel('1, '1);
      drain_results();

      // extreme registers: saturating c
      load_view(longint'(Z_MAX), longint'(Z_MIN), '1, '1, ITER_W'(5));
      send_pixel('0, '0);
      send_pixel('1, '1);
      send_pixel(11'd1, 11'd1024);
      drain_results();

      // slow interior points: c = -0.5 and c = 0.25
      load_view(-(64'sd1 <<< (FRAC_BITS - 1)), 0, '0, '0, ITER_W'(1000));
      send_pixel(11'd7, 11'd9);
      drain_results();
      load_view(64'sd1 <<< (FRAC_BITS - 2), 0, '0, '0, ITER_W'(1000));
      send_pixel(11'd2047, 11'd3);
      drain_results();

      // receiver stalls long enough to back up the request side
      load_view(-(64'sd1 <<< FRAC_BITS), -(64'sd1 <<< (FRAC_BITS - 1)),
                STEP_W'(64'd1 << 29), STEP_W'(64'd1 << 29), ITER_W'(6));
      rsp_hold_cycles = 1500;
      rsp_hold_count++;
      req_burst_left = 8;
      for (int k = 0; k < 8; k++) begin
         send_pixel(draw_index(), draw_index());
      end
      drain_results();

      while (random_sent < RANDOM_ITEMS) begin
         random_view();
         phase_items = $urandom_range(10, 40);
         for (int k = 0; k < phase_items; k++) begin
            send_pixel(draw_index(), draw_index());
            random_sent++;
         end
         drain_results();
      end

      repeat (END_SLACK) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_mandelbrot_escape_pixel: PASS");
      end else begin
         $display("tb_mandelbrot_escape_pixel: FAIL");
      end
      $finish;
   end

endmodule

[mandelbrot_escape_pixel.f]
hw/rtl/mep_pkg.sv
hw/rtl/mep_if.sv
hw/rtl/mep_csr.sv
hw/rtl/mep_mac.sv
hw/rtl/mep_core.sv
hw/rtl/mandelbrot_escape_pixel.sv
hw/rtl/mep_checker.sv
sim/mep_escape_checker.sv
sim/tb_mandelbrot_escape_pixel.sv
